// ===== design/trr_pkg.sv =====
// ----------------------------------------------------------------------------
// Tapered runner renderer package
// Shared types, constants and command/status structs for the renderer.
// ----------------------------------------------------------------------------
package trr_pkg;

    localparam int DEF_MAX_PIXELS   = 128;
    localparam int DEF_MAX_SEGMENTS = 8;

    // Width of the shared serial divider operands.
    localparam int DIV_W = 16;

    localparam logic [7:0] PIXEL_COUNT_RESET = 8'd31;
    localparam logic [7:0] MIN_COUNT         = 8'd2;
    localparam logic [6:0] PERCENT_FULL      = 7'd100;
    localparam logic [7:0] CHAN_MAX          = 8'd255;

    // Multiplying by LEN_RECIP and dropping LEN_SHIFT bits divides by 100
    // exactly for every length product up to 100 * 255.
    localparam logic [12:0] LEN_RECIP = 13'd5243;
    localparam int          LEN_SHIFT = 19;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_SET     = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_READ    = 2'd3
    } trr_op_t;

    typedef enum logic [1:0] {
        DIV_START,
        DIV_POS,
        DIV_CHAN
    } trr_div_sel_t;

    typedef enum logic [2:0] {
        STORE_NONE,
        STORE_SET,
        STORE_ADV,
        STORE_N,
        STORE_CHAN
    } trr_store_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MOD,
        ST_MOD_WAIT,
        ST_NDIV,
        ST_CDIV,
        ST_CDIV_WAIT,
        ST_PIX_A,
        ST_PIX_B,
        ST_DONE
    } trr_state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [2:0]        segment_index;
        logic [14:0]       start_position;
        logic signed [9:0] speed;
        logic [6:0]        length_percent;
        logic [23:0]       segment_color;
        logic [6:0]        pixel_index;
    } trr_item_t;

    typedef struct packed {
        logic         load;
        logic         clear;
        logic         rd_issue;
        logic         div_start;
        trr_div_sel_t div_sel;
        trr_store_t   store;
        logic [1:0]   ch;
        logic         pix_a;
        logic         pix_b;
        logic         finish;
    } trr_cmd_t;

    typedef struct packed {
        trr_op_t op;
        logic    seg_ok;
        logic    div_done;
        logic    last;
        logic    out_free;
    } trr_status_t;

endpackage

// ===== design/trr_in_if.sv =====
// ----------------------------------------------------------------------------
// Renderer request channel
// Valid/ready channel carrying one operation request.
// ----------------------------------------------------------------------------
interface trr_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [2:0]        segment_index;
    logic [14:0]       start_position;
    logic signed [9:0] speed;
    logic [6:0]        length_percent;
    logic [23:0]       segment_color;
    logic [6:0]        pixel_index;

    modport source (
        output valid, operation, segment_index, start_position, speed,
               length_percent, segment_color, pixel_index,
        input  ready
    );
    modport sink (
        input  valid, operation, segment_index, start_position, speed,
               length_percent, segment_color, pixel_index,
        output ready
    );
endinterface

// ===== design/trr_out_if.sv =====
// ----------------------------------------------------------------------------
// Renderer result channel
// Valid/ready channel carrying the pixel read and the segment position.
// ----------------------------------------------------------------------------
interface trr_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_color;
    logic [14:0] segment_position;

    modport source (
        output valid, pixel_color, segment_position,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, segment_position,
        output ready
    );
endinterface

// ===== design/trr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Renderer configuration channel
// Valid/ready write channel for the pixel count register.
// ----------------------------------------------------------------------------
interface trr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// ===== design/trr_divider.sv =====
// ----------------------------------------------------------------------------
// Renderer serial divider
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module trr_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [trr_pkg::DIV_W-1:0] dividend,
    input  logic [trr_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [trr_pkg::DIV_W-1:0] quotient,
    output logic [trr_pkg::DIV_W-1:0] remainder
);
    localparam int CNT_W = $clog2(trr_pkg::DIV_W);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [trr_pkg::DIV_W-1:0] dvd_reg;
    logic [trr_pkg::DIV_W-1:0] dvs_reg;
    logic [trr_pkg::DIV_W:0]   rem_reg;
    logic [trr_pkg::DIV_W-1:0] quo_reg;
    logic [trr_pkg::DIV_W:0]   trial;
    logic                      fits;

    assign trial = {rem_reg[trr_pkg::DIV_W-1:0], dvd_reg[trr_pkg::DIV_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(trr_pkg::DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[trr_pkg::DIV_W-2:0], 1'b0};
            rem_reg <= fits ? (trial - {1'b0, dvs_reg}) : trial;
            quo_reg <= {quo_reg[trr_pkg::DIV_W-2:0], fits};
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[trr_pkg::DIV_W-1:0];

endmodule

// ===== design/trr_datapath.sv =====
// ----------------------------------------------------------------------------
// Renderer datapath
// Frame store, runner positions, taper and blend arithmetic, result register.
// ----------------------------------------------------------------------------
module trr_datapath #(
    parameter int MAX_PIXELS   = trr_pkg::DEF_MAX_PIXELS,
    parameter int MAX_SEGMENTS = trr_pkg::DEF_MAX_SEGMENTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  trr_pkg::trr_cmd_t   cmd,
    output trr_pkg::trr_status_t status,
    input  trr_pkg::trr_item_t  item,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    trr_out_if.source           results
);
    localparam int PIX_W = $clog2(MAX_PIXELS);
    localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int POS_W = $clog2(MAX_PIXELS * 256);
    localparam logic [7:0] MAX_CNT = 8'(MAX_PIXELS);

    logic [7:0]              pixel_count_reg;
    trr_pkg::trr_op_t        op_reg;
    logic [2:0]              seg_reg;
    logic [14:0]             start_reg;
    logic signed [9:0]       speed_reg;
    logic [6:0]              len_reg;
    logic [23:0]             color_reg;
    logic [6:0]              pidx_reg;
    logic [7:0]              count_reg;
    logic [POS_W-1:0]        pos_reg [MAX_SEGMENTS];
    logic [7:0]              n_reg;
    logic [7:0]              step_reg [3];
    logic [7:0]              pix_reg;
    logic [7:0]              frac_reg;
    logic [7:0]              i_reg;
    logic [23:0]             tap_prev_reg;
    logic [23:0]             tap_next_reg;
    logic [23:0]             rdata_reg;
    logic                    rvld_reg;
    logic [MAX_PIXELS-1:0]   vld_reg;
    logic [23:0]             mem [MAX_PIXELS];
    logic                    out_valid_reg;
    logic [23:0]             pixel_color_reg;
    logic [14:0]             segment_position_reg;

    logic [7:0]                count_clamp;
    logic [6:0]                len_sat;
    logic                      seg_ok;
    logic [6:0]                seg_ext;
    logic [SEG_W-1:0]          seg_idx;
    logic [POS_W-1:0]          cur_pos;
    logic [trr_pkg::DIV_W-1:0] total;
    logic [14:0]               len_prod;
    logic [27:0]               len_mul;
    logic [8:0]                len_quot;
    logic [7:0]                chan_sel;
    logic [trr_pkg::DIV_W-1:0] div_dvd;
    logic [trr_pkg::DIV_W-1:0] div_dvs;
    logic                      div_busy;
    logic                      div_done;
    logic [trr_pkg::DIV_W-1:0] div_quot;
    logic [trr_pkg::DIV_W-1:0] div_rem;
    logic signed [17:0]        total_s;
    logic signed [17:0]        adv_t0;
    logic signed [17:0]        adv_t1;
    logic signed [17:0]        adv_pos;
    logic [8:0]                p9;
    logic [8:0]                n9;
    logic [8:0]                c9;
    logic [8:0]                k9;
    logic                      tap_zero;
    logic [23:0]               tap_val;
    logic [23:0]               pix_new;
    logic [8:0]                wa;
    logic [8:0]                wb;
    logic [23:0]               old_pix;
    logic [PIX_W-1:0]          pix_addr;
    logic [7:0]                pidx_ext;
    logic [PIX_W-1:0]          rd_addr;
    logic                      pidx_ok;
    logic [8:0]                pix_inc;
    logic [trr_pkg::DIV_W-1:0] pos_wide;

    assign count_clamp = (pixel_count_reg < trr_pkg::MIN_COUNT) ? trr_pkg::MIN_COUNT :
                         (pixel_count_reg > MAX_CNT) ? MAX_CNT : pixel_count_reg;
    assign len_sat  = (len_reg > trr_pkg::PERCENT_FULL) ? trr_pkg::PERCENT_FULL : len_reg;
    assign seg_ok   = (32'(seg_reg) < MAX_SEGMENTS);
    assign seg_ext  = {4'b0, seg_reg};
    assign seg_idx  = seg_ext[SEG_W-1:0];
    assign cur_pos  = pos_reg[seg_idx];
    assign pos_wide = trr_pkg::DIV_W'(cur_pos);
    assign total    = {count_reg, 8'b0};
    assign len_prod = 15'(len_sat) * 15'(count_reg);
    assign len_mul  = 28'(len_prod) * 28'(trr_pkg::LEN_RECIP);
    assign len_quot = len_mul[trr_pkg::LEN_SHIFT +: 9];
    assign pidx_ext = {1'b0, pidx_reg};
    assign pidx_ok  = (32'(pidx_reg) < MAX_PIXELS);
    assign pix_addr = pix_reg[PIX_W-1:0];
    assign rd_addr  = cmd.pix_a ? pix_addr : pidx_ext[PIX_W-1:0];
    assign pix_inc  = {1'b0, pix_reg} + 9'd1;

    always_comb
    begin
        case (cmd.ch)
            2'd1:    chan_sel = color_reg[15:8];
            2'd2:    chan_sel = color_reg[23:16];
            default: chan_sel = color_reg[7:0];
        endcase
    end

    always_comb
    begin
        case (cmd.div_sel)
            trr_pkg::DIV_START:
            begin
                div_dvd = trr_pkg::DIV_W'(start_reg);
                div_dvs = total;
            end
            trr_pkg::DIV_POS:
            begin
                div_dvd = pos_wide;
                div_dvs = total;
            end
            default:
            begin
                div_dvd = trr_pkg::DIV_W'(chan_sel);
                div_dvs = trr_pkg::DIV_W'(n_reg[7:1]) + 1'b1;
            end
        endcase
    end

    trr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // The reduced position plus the speed lands at most one range away.
    assign total_s = $signed({2'b0, total});
    assign adv_t0  = $signed({2'b0, div_rem}) + 18'(speed_reg);
    assign adv_t1  = (adv_t0 < 0) ? adv_t0 + total_s : adv_t0;
    assign adv_pos = (adv_t1 >= total_s) ? adv_t1 - total_s : adv_t1;

    // Taper of slot i+1: rises to the centre, falls after it, zero past the end.
    assign p9       = {1'b0, i_reg} + 9'd1;
    assign n9       = {1'b0, n_reg};
    assign c9       = {2'b0, n_reg[7:1]};
    assign tap_zero = (p9 == n9 + 9'd1);
    assign k9       = (p9 <= c9) ? p9 + 9'd1 : n9 - p9;

    always_comb
    begin
        logic [15:0] prod;
        tap_val = '0;
        for (int l = 0; l < 3; l++)
        begin
            prod = step_reg[l] * {8'b0, k9[7:0]};
            tap_val[l*8 +: 8] = tap_zero ? 8'd0 : prod[7:0];
        end
    end

    assign wa      = {1'b0, frac_reg} + 9'd1;
    assign wb      = {1'b0, trr_pkg::CHAN_MAX - frac_reg};
    assign old_pix = rvld_reg ? rdata_reg : 24'd0;

    always_comb
    begin
        logic [16:0] acc;
        logic [8:0]  s;
        pix_new = '0;
        for (int l = 0; l < 3; l++)
        begin
            acc = 17'(tap_prev_reg[l*8 +: 8]) * 17'(wa)
                + 17'(tap_next_reg[l*8 +: 8]) * 17'(wb);
            s = {1'b0, old_pix[l*8 +: 8]} + {1'b0, acc[15:8]};
            pix_new[l*8 +: 8] = s[8] ? trr_pkg::CHAN_MAX : s[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= trr_pkg::PIXEL_COUNT_RESET;
            out_valid_reg   <= 1'b0;
            vld_reg         <= '0;
            for (int s = 0; s < MAX_SEGMENTS; s++)
            begin
                pos_reg[s] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                pixel_count_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clear)
            begin
                vld_reg <= '0;
            end
            else if (cmd.pix_b)
            begin
                vld_reg[pix_addr] <= 1'b1;
            end
            if (cmd.store == trr_pkg::STORE_SET)
            begin
                pos_reg[seg_idx] <= div_rem[POS_W-1:0];
            end
            else if (cmd.store == trr_pkg::STORE_ADV)
            begin
                pos_reg[seg_idx] <= adv_pos[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= trr_pkg::trr_op_t'(item.operation);
            seg_reg   <= item.segment_index;
            start_reg <= item.start_position;
            speed_reg <= item.speed;
            len_reg   <= item.length_percent;
            color_reg <= item.segment_color;
            pidx_reg  <= item.pixel_index;
            count_reg <= count_clamp;
        end
        case (cmd.store)
            trr_pkg::STORE_ADV:
            begin
                pix_reg  <= adv_pos[15:8];
                frac_reg <= adv_pos[7:0];
            end
            trr_pkg::STORE_N:
            begin
                n_reg        <= (len_quot < 9'(trr_pkg::MIN_COUNT)) ?
                                trr_pkg::MIN_COUNT : len_quot[7:0];
                i_reg        <= '0;
                tap_prev_reg <= '0;
            end
            trr_pkg::STORE_CHAN:
            begin
                step_reg[cmd.ch] <= div_quot[7:0];
            end
            default:
            begin
            end
        endcase
        if (cmd.pix_a)
        begin
            tap_next_reg <= tap_val;
        end
        if (cmd.pix_b)
        begin
            mem[pix_addr] <= pix_new;
            tap_prev_reg  <= tap_next_reg;
            i_reg         <= i_reg + 1'b1;
            pix_reg       <= (pix_inc >= {1'b0, count_reg}) ? 8'd0 : pix_inc[7:0];
        end
        if (cmd.pix_a || cmd.rd_issue)
        begin
            rdata_reg <= mem[rd_addr];
            rvld_reg  <= vld_reg[rd_addr];
        end
        if (cmd.finish)
        begin
            pixel_color_reg      <= (op_reg == trr_pkg::OP_READ && pidx_ok && rvld_reg) ?
                                    rdata_reg : 24'd0;
            segment_position_reg <= seg_ok ? pos_wide[14:0] : 15'd0;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.pixel_color      = pixel_color_reg;
    assign results.segment_position = segment_position_reg;

    assign status.op       = op_reg;
    assign status.seg_ok   = seg_ok;
    assign status.div_done = div_done;
    assign status.last     = (i_reg == n_reg);
    assign status.out_free = !out_valid_reg || results.ready;

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_pix_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pix_a |-> (pix_reg < count_reg))
        else $error("draw address outside the strip");
    a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pix_a |-> (n_reg >= trr_pkg::MIN_COUNT))
        else $error("segment shorter than two pixels");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> results.valid)
        else $error("finished request produced no result");

endmodule

// ===== design/trr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Renderer controller
// Sequences requests through the divider, the pixel loop and the result.
// ----------------------------------------------------------------------------
module trr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output trr_pkg::trr_cmd_t    cmd,
    input  trr_pkg::trr_status_t status
);
    trr_pkg::trr_state_t state_reg;
    trr_pkg::trr_state_t state_next;
    logic [1:0]          ch_reg;
    logic [1:0]          ch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trr_pkg::ST_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.div_sel   = trr_pkg::DIV_CHAN;
        cmd.store     = trr_pkg::STORE_NONE;
        cmd.ch        = ch_reg;
        unique case (state_reg)
            trr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = trr_pkg::ST_DISPATCH;
                end
            end
            trr_pkg::ST_DISPATCH:
            begin
                unique case (status.op) inside
                    trr_pkg::OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = trr_pkg::ST_DONE;
                    end
                    trr_pkg::OP_READ:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = trr_pkg::ST_DONE;
                    end
                    trr_pkg::OP_SET, trr_pkg::OP_ADVANCE:
                    begin
                        state_next = status.seg_ok ? trr_pkg::ST_MOD : trr_pkg::ST_DONE;
                    end
                endcase
            end
            trr_pkg::ST_MOD:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = (status.op == trr_pkg::OP_SET) ?
                                trr_pkg::DIV_START : trr_pkg::DIV_POS;
                state_next    = trr_pkg::ST_MOD_WAIT;
            end
            trr_pkg::ST_MOD_WAIT:
            begin
                if (status.div_done)
                begin
                    if (status.op == trr_pkg::OP_SET)
                    begin
                        cmd.store  = trr_pkg::STORE_SET;
                        state_next = trr_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.store  = trr_pkg::STORE_ADV;
                        state_next = trr_pkg::ST_NDIV;
                    end
                end
            end
            trr_pkg::ST_NDIV:
            begin
                cmd.store  = trr_pkg::STORE_N;
                ch_next    = '0;
                state_next = trr_pkg::ST_CDIV;
            end
            trr_pkg::ST_CDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = trr_pkg::DIV_CHAN;
                state_next    = trr_pkg::ST_CDIV_WAIT;
            end
            trr_pkg::ST_CDIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.store = trr_pkg::STORE_CHAN;
                    if (ch_reg == 2'd2)
                    begin
                        state_next = trr_pkg::ST_PIX_A;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = trr_pkg::ST_CDIV;
                    end
                end
            end
            trr_pkg::ST_PIX_A:
            begin
                cmd.pix_a  = 1'b1;
                state_next = trr_pkg::ST_PIX_B;
            end
            trr_pkg::ST_PIX_B:
            begin
                cmd.pix_b  = 1'b1;
                state_next = status.last ? trr_pkg::ST_DONE : trr_pkg::ST_PIX_A;
            end
            trr_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = trr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = trr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tapered_runner_led_renderer_top.sv =====
// ----------------------------------------------------------------------------
// Tapered runner LED renderer
// Draws moving tapered segments into an RGB frame store and reads pixels back.
// ----------------------------------------------------------------------------
// Channels: cfg writes the pixel count; items carries one request (clear,
// set position, advance and draw, read pixel); results returns one item per
// request with the read pixel color and the addressed segment position.
// One request is worked on at a time. Advance and draw writes n + 1 pixels,
// where n is the segment length in pixels (at most 128). The shared serial
// divider does four divisions per draw: the position wrap and one per color
// channel. Each pixel is a read-modify-write on the single-port frame store.
// Reset clears the runner positions, the frame valid bits (so every pixel
// reads zero at once) and sets the pixel count to 31; no clearing pass runs.
// When the receiver stalls the result register holds its request; the next
// request is still accepted and worked on, and its result waits for the
// register to free up.
// ----------------------------------------------------------------------------
module tapered_runner_led_renderer_top #(
    parameter int MAX_PIXELS   = trr_pkg::DEF_MAX_PIXELS,
    parameter int MAX_SEGMENTS = trr_pkg::DEF_MAX_SEGMENTS
) (
    input  logic       clk,
    input  logic       rst_n,
    trr_cfg_if.sink    cfg,
    trr_in_if.sink     items,
    trr_out_if.source  results
);
    trr_pkg::trr_cmd_t    cmd;
    trr_pkg::trr_status_t status;
    trr_pkg::trr_item_t   item;
    logic                 ctrl_ready;

    assign cfg.ready   = 1'b1;
    assign items.ready = ctrl_ready;

    assign item.operation      = items.operation;
    assign item.segment_index  = items.segment_index;
    assign item.start_position = items.start_position;
    assign item.speed          = items.speed;
    assign item.length_percent = items.length_percent;
    assign item.segment_color  = items.segment_color;
    assign item.pixel_index    = items.pixel_index;

    trr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (ctrl_ready),
        .cmd      (cmd),
        .status   (status)
    );

    trr_datapath #(
        .MAX_PIXELS   (MAX_PIXELS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .results   (results)
    );

endmodule
